// ===== design/gki_pkg.sv =====
package gki_pkg;

   // table size default
   localparam int MAX_KEYS_DEF = 16;

   // field widths
   localparam int POS_W  = 17;
   localparam int COL_W  = 32;
   localparam int VAL_W  = 16;
   localparam int STAT_W = 2;

   // 1.0 in unsigned q1.16
   localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_QUERY    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_INSERTED = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;

   // end keys after reset: white transparent, green opaque, size 1.0
   localparam logic [COL_W-1:0] END0_COLOR = 32'hFFFFFF00;
   localparam logic [COL_W-1:0] END1_COLOR = 32'h00FF00FF;
   localparam logic [VAL_W-1:0] END_SIZE   = 16'h0100;

   typedef struct packed {
      logic [POS_W-1:0]        pos;
      logic [COL_W-1:0]        color;
      logic signed [VAL_W-1:0] size;
      logic signed [VAL_W-1:0] rot;
   } key_type;

endpackage

// ===== design/gradient_key_interpolator_top.sv =====
// gradient key interpolator
//
// req channel (valid/ready): one item is an insert (req_type 0) or a query (req_type 1)
// at req_position, unsigned q1.16, saturated to 1.0; an insert replaces the key at that
// position or appends one, and an insert at 0 or 1.0 replaces an end key; a full table
// drops the insert and reports status 2; a query blends colour, size and rotation between
// the nearest keys strictly below and strictly above, each channel rounded toward zero
// rsp channel (valid/ready): exactly one result item per request item
//
// timing: an item is worked on alone; the key table is scanned one entry a cycle through
// the registered read port of the key memory, from entry two up to one below the key count;
// an insert then updates the table and moves to the output state; a query goes on through
// one shared multiplier and a one bit per cycle divider, channel by channel in the order
// red, green, blue, alpha, size, rotation: the lower key times its weight, plus the upper
// key times its weight, then the divider is loaded with the sum and run to the quotient (8
// bits for colour, 16 for size and rotation); after rotation the item goes to the output state
// req_ready is high only while the sequencer is idle; a finished item waits in an
// output register, so a stalled receiver holds the next result in the sequencer until
// the output register frees, and the block takes no new item meanwhile
// reset (synchronous) restores the two end keys and a key count of two; no clearing pass
module gradient_key_interpolator_top
   import gki_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [POS_W-1:0]         req_position,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   input  logic [7:0]               req_alpha,
   input  logic signed [VAL_W-1:0]  req_size_value,
   input  logic signed [VAL_W-1:0]  req_rotation,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_red,
   output logic [7:0]               rsp_out_green,
   output logic [7:0]               rsp_out_blue,
   output logic [7:0]               rsp_out_alpha,
   output logic signed [VAL_W-1:0]  rsp_out_size,
   output logic signed [VAL_W-1:0]  rsp_out_rotation,
   output logic [STAT_W-1:0]        rsp_status
);

   localparam int IDX_W = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int ACC_W = 34;
   localparam int NUM_CH = 6;

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SCAN = 4'd1;
   localparam logic [3:0] ST_INS  = 4'd2;
   localparam logic [3:0] ST_PREP = 4'd3;
   localparam logic [3:0] ST_MUL0 = 4'd4;
   localparam logic [3:0] ST_MUL1 = 4'd5;
   localparam logic [3:0] ST_LOAD = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   // channel order
   localparam logic [2:0] CH_RED   = 3'd0;
   localparam logic [2:0] CH_GREEN = 3'd1;
   localparam logic [2:0] CH_BLUE  = 3'd2;
   localparam logic [2:0] CH_ALPHA = 3'd3;
   localparam logic [2:0] CH_SIZE  = 3'd4;
   localparam logic [2:0] CH_ROT   = 3'd5;

   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEYS);

   // picks one channel of a key, widened to 17 bits signed
   function automatic logic signed [16:0] chan_val(input key_type k, input logic [2:0] ch);
      logic signed [16:0] v;
      case (ch)
         CH_RED:   v = $signed({9'd0, k.color[31:24]});
         CH_GREEN: v = $signed({9'd0, k.color[23:16]});
         CH_BLUE:  v = $signed({9'd0, k.color[15:8]});
         CH_ALPHA: v = $signed({9'd0, k.color[7:0]});
         CH_SIZE:  v = {k.size[VAL_W-1], k.size};
         CH_ROT:   v = {k.rot[VAL_W-1], k.rot};
         default:  v = '0;
      endcase
      return v;
   endfunction

   // control state
   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   key_type            end0_ff, end0_in;
   key_type            end1_ff, end1_in;

   // working registers
   logic               type_ff, type_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   key_type            new_ff, new_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rdv_ff, rdv_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               match_ff, match_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   key_type            lo_ff, lo_in;
   key_type            hi_ff, hi_in;
   logic [POS_W-1:0]   w0_ff, w0_in;
   logic [POS_W-1:0]   w1_ff, w1_in;
   logic [POS_W-1:0]   den_ff, den_in;
   logic [2:0]         ch_ff, ch_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [POS_W-1:0]   rem_ff, rem_in;
   logic [VAL_W-1:0]   quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [VAL_W-1:0]   res_ff [NUM_CH];
   logic [VAL_W-1:0]   res_in [NUM_CH];
   logic [STAT_W-1:0]  res_stat_ff, res_stat_in;
   logic [VAL_W-1:0]   rsp_val_ff [NUM_CH];
   logic [STAT_W-1:0]  rsp_stat_ff;

   // key memory, entries from two up to one below the key count hold valid keys
   key_type            key_mem [MAX_KEYS];
   key_type            rd_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;

   // shared multiplier and divider step
   logic signed [16:0] mul_a;
   logic [POS_W-1:0]   mul_b;
   logic signed [34:0] prod;
   logic [ACC_W-1:0]   mag;
   logic [POS_W:0]     rem_shift;
   logic               rem_ge;
   logic [VAL_W-1:0]   quo_next;
   logic [VAL_W-1:0]   quo_signed;
   logic               rsp_load;

   assign rd_addr = idx_ff[IDX_W-1:0];

   assign mul_a = (state_ff == ST_MUL0) ? chan_val(lo_ff, ch_ff) : chan_val(hi_ff, ch_ff);
   assign mul_b = (state_ff == ST_MUL0) ? w0_ff : w1_ff;
   assign prod  = mul_a * $signed({1'b0, mul_b});

   assign mag        = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;
   assign rem_shift  = {rem_ff, quo_ff[VAL_W-1]};
   assign rem_ge     = (rem_shift >= {1'b0, den_ff});
   assign quo_next   = {quo_ff[VAL_W-2:0], rem_ge};
   assign quo_signed = neg_ff ? (~quo_next + VAL_W'(1)) : quo_next;

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      end0_in     = end0_ff;
      end1_in     = end1_ff;
      type_in     = type_ff;
      pos_in      = pos_ff;
      new_in      = new_ff;
      idx_in      = idx_ff;
      rdv_in      = 1'b0;
      rd_idx_in   = rd_idx_ff;
      match_in    = match_ff;
      slot_in     = slot_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      w0_in       = w0_ff;
      w1_in       = w1_ff;
      den_in      = den_ff;
      ch_in       = ch_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      res_in      = res_ff;
      res_stat_in = res_stat_ff;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in       = req_type;
               pos_in        = (req_position > POS_ONE) ? POS_ONE : req_position;
               new_in.pos    = pos_in;
               new_in.color  = {req_red, req_green, req_blue, req_alpha};
               new_in.size   = req_size_value;
               new_in.rot    = req_rotation;
               idx_in        = CNT_TWO;
               match_in      = 1'b0;
               lo_in         = end0_ff;
               hi_in         = end1_ff;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one table read per cycle, compare on the registered read data
            if (idx_ff < count_ff) begin
               rdv_in    = 1'b1;
               rd_idx_in = idx_ff[IDX_W-1:0];
               idx_in    = idx_ff + CNT_W'(1);
            end
            if (rdv_ff) begin
               if (rd_ff.pos == pos_ff) begin
                  match_in = 1'b1;
                  slot_in  = rd_idx_ff;
               end
               if (rd_ff.pos > lo_ff.pos && rd_ff.pos < pos_ff) begin
                  lo_in = rd_ff;
               end
               if (rd_ff.pos < hi_ff.pos && rd_ff.pos > pos_ff) begin
                  hi_in = rd_ff;
               end
            end
            if (idx_ff >= count_ff && !rdv_ff) begin
               state_in = (type_ff == REQ_QUERY) ? ST_PREP : ST_INS;
            end
         end
         ST_INS: begin
            for (int c = 0; c < NUM_CH; c++) begin
               res_in[c] = '0;
            end
            res_stat_in = STATUS_INSERTED;
            if (pos_ff == '0) begin
               end0_in = new_ff;
            end else if (pos_ff == POS_ONE) begin
               end1_in = new_ff;
            end else if (match_ff) begin
               wr_en = 1'b1;
            end else if (count_ff == CNT_MAX) begin
               res_stat_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_OUT;
         end
         ST_PREP: begin
            w1_in    = pos_ff - lo_ff.pos;
            w0_in    = hi_ff.pos - pos_ff;
            den_in   = hi_ff.pos - lo_ff.pos;
            ch_in    = CH_RED;
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            // lo * (hi_pos - pos)
            acc_in   = prod[ACC_W-1:0];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            // + hi * (pos - lo_pos)
            acc_in   = acc_ff + prod[ACC_W-1:0];
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // quotient fits 8 bits for colour, 16 for size and rotation
            neg_in = acc_ff[ACC_W-1];
            if (ch_ff < CH_SIZE) begin
               rem_in = mag[24:8];
               quo_in = {mag[7:0], 8'd0};
               cnt_in = 5'd8;
            end else begin
               rem_in = {1'b0, mag[31:16]};
               quo_in = mag[15:0];
               cnt_in = 5'd16;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = rem_ge ? POS_W'(rem_shift - {1'b0, den_ff}) : rem_shift[POS_W-1:0];
            quo_in = quo_next;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               res_in[ch_ff] = quo_signed;
               if (ch_ff == CH_ROT) begin
                  res_stat_in = STATUS_QUERY;
                  state_in    = ST_OUT;
               end else begin
                  ch_in    = ch_ff + 3'd1;
                  state_in = ST_MUL0;
               end
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_TWO;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         end0_ff      <= '{pos: '0, color: END0_COLOR, size: END_SIZE, rot: '0};
         end1_ff      <= '{pos: POS_ONE, color: END1_COLOR, size: END_SIZE, rot: '0};
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rdv_in;
         end0_ff      <= end0_in;
         end1_ff      <= end1_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      pos_ff      <= pos_in;
      new_ff      <= new_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      match_ff    <= match_in;
      slot_ff     <= slot_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      den_ff      <= den_in;
      ch_ff       <= ch_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      res_stat_ff <= res_stat_in;
      if (rsp_load) begin
         rsp_val_ff  <= res_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   // key memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= new_ff;
      end
      rd_ff <= key_mem[rd_addr];
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_val_ff[CH_RED][7:0];
   assign rsp_out_green    = rsp_val_ff[CH_GREEN][7:0];
   assign rsp_out_blue     = rsp_val_ff[CH_BLUE][7:0];
   assign rsp_out_alpha    = rsp_val_ff[CH_ALPHA][7:0];
   assign rsp_out_size     = $signed(rsp_val_ff[CH_SIZE]);
   assign rsp_out_rotation = $signed(rsp_val_ff[CH_ROT]);
   assign rsp_status       = rsp_stat_ff;

endmodule

// ===== design/gki_checker.sv =====
module gki_checker
   import gki_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [7:0]               rsp_out_red,
   input logic [7:0]               rsp_out_green,
   input logic [7:0]               rsp_out_blue,
   input logic [7:0]               rsp_out_alpha,
   input logic signed [VAL_W-1:0]  rsp_out_size,
   input logic signed [VAL_W-1:0]  rsp_out_rotation,
   input logic [STAT_W-1:0]        rsp_status
);

   // items accepted whose result has not been taken
   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a result only for an item that was taken
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an accepted item");

   // one item at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted item");

   // inserts carry only status
   a_insert_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_QUERY |->
         rsp_out_red == 8'd0 && rsp_out_green == 8'd0 && rsp_out_blue == 8'd0 &&
         rsp_out_alpha == 8'd0 && rsp_out_size == '0 && rsp_out_rotation == '0)
      else $error("insert result with non-zero values");

   // stalled result holds: valid, status, size, rotation and red are checked
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_out_size) && $stable(rsp_out_rotation) && $stable(rsp_out_red))
      else $error("stalled result changed");

endmodule

bind gradient_key_interpolator_top gki_checker u_gki_checker (.*);

// ===== verif/testbench.sv =====
module testbench;
   import gki_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // one request item as offered on the req_ channel
   typedef struct packed {
      logic                    kind;
      logic [POS_W-1:0]        pos;
      logic [7:0]              red;
      logic [7:0]              green;
      logic [7:0]              blue;
      logic [7:0]              alpha;
      logic signed [VAL_W-1:0] size;
      logic signed [VAL_W-1:0] rot;
   } gradient_req_type;

   // one result item as seen on the rsp_ channel
   typedef struct packed {
      logic [7:0]              red;
      logic [7:0]              green;
      logic [7:0]              blue;
      logic [7:0]              alpha;
      logic signed [VAL_W-1:0] size;
      logic signed [VAL_W-1:0] rot;
      logic [STAT_W-1:0]       status;
   } gradient_rsp_type;

   // directed row: the item, and a hand-written result where one is obvious
   typedef struct packed {
      gradient_req_type item;
      logic             typed;
      gradient_rsp_type want;
   } ramp_row_type;

   localparam int RANDOM_ITEMS = 1228;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 150;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AT      = 200;

   localparam gradient_rsp_type NO_RESULT   = '0;
   localparam gradient_rsp_type INSERTED_OK = '{8'd0, 8'd0, 8'd0, 8'd0, 16'sd0, 16'sd0,
                                                STATUS_INSERTED};
   // end keys exactly as they come out of reset
   localparam gradient_rsp_type AT_END0 = '{8'd255, 8'd255, 8'd255, 8'd0, 16'sh0100, 16'sd0,
                                            STATUS_QUERY};
   localparam gradient_rsp_type AT_END1 = '{8'd0, 8'd255, 8'd0, 8'd255, 16'sh0100, 16'sd0,
                                            STATUS_QUERY};
   // halfway between the reset end keys, every channel truncated
   localparam gradient_rsp_type AT_HALF = '{8'd127, 8'd255, 8'd127, 8'd127, 16'sh0100, 16'sd0,
                                            STATUS_QUERY};

   localparam int DIRECTED_N = 22;
   localparam ramp_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      // queries against the reset table: both ends, saturation, midpoint
      '{'{REQ_QUERY, 17'h00000, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b1, AT_END0},
      '{'{REQ_QUERY, 17'h10000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'shFFFF, 16'shFFFF},
        1'b1, AT_END1},
      '{'{REQ_QUERY, 17'h1FFFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b1, AT_END1},
      '{'{REQ_QUERY, 17'h08000, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b1, AT_HALF},
      // rewrite both end keys with extreme values, the upper one via saturation
      '{'{REQ_INSERT, 17'h00000, 8'h00, 8'h00, 8'h00, 8'hFF, 16'sh8000, 16'sh7FFF},
        1'b1, INSERTED_OK},
      '{'{REQ_INSERT, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 16'sh7FFF, 16'sh8000},
        1'b1, INSERTED_OK},
      '{'{REQ_QUERY, 17'h00001, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      '{'{REQ_QUERY, 17'h0FFFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      '{'{REQ_QUERY, 17'h08000, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      // an inner key, then queries on it and either side of it
      '{'{REQ_INSERT, 17'h08000, 8'hA5, 8'h5A, 8'h0F, 8'hF0, 16'sh0100, 16'shFF00},
        1'b1, INSERTED_OK},
      '{'{REQ_QUERY, 17'h08000, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      '{'{REQ_QUERY, 17'h07FFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      '{'{REQ_QUERY, 17'h08001, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      // append, then replace the same position
      '{'{REQ_INSERT, 17'h04000, 8'h11, 8'h22, 8'h33, 8'h44, 16'sh1234, 16'shEDCC},
        1'b1, INSERTED_OK},
      '{'{REQ_INSERT, 17'h04000, 8'hC3, 8'h3C, 8'h81, 8'h7E, 16'shC000, 16'sh4000},
        1'b1, INSERTED_OK},
      '{'{REQ_QUERY, 17'h04000, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      '{'{REQ_QUERY, 17'h04E20, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      '{'{REQ_INSERT, 17'h0C000, 8'h80, 8'h01, 8'hFE, 8'h7F, 16'sh0001, 16'shFFFE},
        1'b1, INSERTED_OK},
      '{'{REQ_QUERY, 17'h00000, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      '{'{REQ_QUERY, 17'h10000, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT},
      '{'{REQ_INSERT, 17'h10000, 8'h7F, 8'h80, 8'h55, 8'hAA, 16'sh0080, 16'shFF80},
        1'b1, INSERTED_OK},
      '{'{REQ_QUERY, 17'h10001, 8'h00, 8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000},
        1'b0, NO_RESULT}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_type;
   logic [POS_W-1:0]        req_position;
   logic [7:0]              req_red;
   logic [7:0]              req_green;
   logic [7:0]              req_blue;
   logic [7:0]              req_alpha;
   logic signed [VAL_W-1:0] req_size_value;
   logic signed [VAL_W-1:0] req_rotation;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [7:0]              rsp_out_red;
   logic [7:0]              rsp_out_green;
   logic [7:0]              rsp_out_blue;
   logic [7:0]              rsp_out_alpha;
   logic signed [VAL_W-1:0] rsp_out_size;
   logic signed [VAL_W-1:0] rsp_out_rotation;
   logic [STAT_W-1:0]       rsp_status;

   // the testbench's own copy of the key table
   key_type          ramp_keys [MAX_KEYS_DEF];
   int               ramp_key_count;

   // results still owed by the block, oldest first
   gradient_rsp_type awaited_results [$];
   gradient_rsp_type arrived;

   int               mismatches;
   int               results_seen;
   int               cycle_count;
   bit               calm;

   gradient_key_interpolator_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_position     (req_position),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .req_size_value   (req_size_value),
      .req_rotation     (req_rotation),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_out_size     (rsp_out_size),
      .rsp_out_rotation (rsp_out_rotation),
      .rsp_status       (rsp_status)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // linear blend of one channel, whole value truncated toward zero
   function automatic longint blend_channel(input longint a, input longint b,
                                            input longint num, input longint den);
      return (a * den + (b - a) * num) / den;
   endfunction

   // works out the result of one accepted item and updates the key table
   function automatic gradient_rsp_type predict_ramp(input gradient_req_type it);
      gradient_rsp_type res;
      logic [POS_W-1:0] p;
      int               slot;
      int               lo;
      int               hi;
      longint           num;
      longint           den;
      key_type          kl;
      key_type          kh;

      res = '0;
      p = (it.pos > POS_ONE) ? POS_ONE : it.pos;

      if (it.kind == REQ_INSERT) begin
         // first key at the same position wins, otherwise append
         slot = ramp_key_count;
         for (int i = 0; i < ramp_key_count; i++) begin
            if (ramp_keys[i].pos == p) begin
               slot = i;
               break;
            end
         end
         if (slot >= MAX_KEYS_DEF) begin
            res.status = STATUS_FULL;
         end else begin
            if (slot == ramp_key_count) ramp_key_count++;
            ramp_keys[slot] = '{p, {it.red, it.green, it.blue, it.alpha}, it.size, it.rot};
            res.status = STATUS_INSERTED;
         end
         return res;
      end

      // neighbours strictly below and above, starting from the end keys
      lo = 0;
      hi = 1;
      for (int i = 2; i < ramp_key_count; i++) begin
         if (ramp_keys[i].pos > ramp_keys[lo].pos && ramp_keys[i].pos < p) lo = i;
         if (ramp_keys[i].pos < ramp_keys[hi].pos && ramp_keys[i].pos > p) hi = i;
      end
      kl = ramp_keys[lo];
      kh = ramp_keys[hi];
      num = longint'(p) - longint'(kl.pos);
      den = longint'(kh.pos) - longint'(kl.pos);
      if (den <= 0) begin
         num = 0;
         den = 1;
      end
      res.red   = 8'(blend_channel(longint'(kl.color[31:24]), longint'(kh.color[31:24]),
                                   num, den));
      res.green = 8'(blend_channel(longint'(kl.color[23:16]), longint'(kh.color[23:16]),
                                   num, den));
      res.blue  = 8'(blend_channel(longint'(kl.color[15:8]), longint'(kh.color[15:8]),
                                   num, den));
      res.alpha = 8'(blend_channel(longint'(kl.color[7:0]), longint'(kh.color[7:0]),
                                   num, den));
      res.size  = 16'(blend_channel(longint'($signed(kl.size)), longint'($signed(kh.size)),
                                    num, den));
      res.rot   = 16'(blend_channel(longint'($signed(kl.rot)), longint'($signed(kh.rot)),
                                    num, den));
      res.status = STATUS_QUERY;
      return res;
   endfunction

   // random item: mostly replaces and queries around the keys that exist,
   // new keys trickle in so the table fills part way through the run
   function automatic gradient_req_type draw_ramp_item(input int n);
      gradient_req_type it;
      int               p;
      int               k;
      bit               clash;

      it.red   = 8'($urandom);
      it.green = 8'($urandom);
      it.blue  = 8'($urandom);
      it.alpha = 8'($urandom);
      it.size  = 16'($urandom);
      it.rot   = 16'($urandom);
      k = $urandom_range(ramp_key_count - 1);

      // new key at a free position, forced late on if the table is not yet full
      if (ramp_key_count < MAX_KEYS_DEF && (n >= 800 || $urandom_range(49) == 0)) begin
         do begin
            p = $urandom_range(65535, 1);
            clash = 1'b0;
            for (int i = 0; i < ramp_key_count; i++)
               if (ramp_keys[i].pos == POS_W'(p)) clash = 1'b1;
         end while (clash);
         it.kind = REQ_INSERT;
         it.pos  = POS_W'(p);
         return it;
      end

      if ($urandom_range(99) < 45) begin
         it.kind = REQ_QUERY;
         case ($urandom_range(7))
            0, 1: p = int'(ramp_keys[k].pos);
            2: p = int'(ramp_keys[k].pos) + 1;
            3: p = (ramp_keys[k].pos == '0) ? 0 : int'(ramp_keys[k].pos) - 1;
            4, 5: p = $urandom_range(65536);
            6: p = $urandom_range(131071, 65537);
            default: begin
               case ($urandom_range(2))
                  0: p = 0;
                  1: p = 65536;
                  default: p = 131071;
               endcase
            end
         endcase
      end else begin
         it.kind = REQ_INSERT;
         if (ramp_key_count == MAX_KEYS_DEF && $urandom_range(4) == 0) begin
            // almost always a fresh position, so the full table drops it
            p = $urandom_range(65535);
         end else begin
            case ($urandom_range(6))
               5: p = $urandom_range(1) ? 65536 : 0;
               6: p = $urandom_range(131071, 65537);
               default: p = int'(ramp_keys[k].pos);
            endcase
         end
      end
      it.pos = POS_W'(p);
      return it;
   endfunction

   // offer one item, keeping valid high across back-to-back items
   task automatic offer_item(input gradient_req_type it, input logic typed,
                             input gradient_rsp_type want);
      gradient_rsp_type due;

      while (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= it.kind;
      req_position   <= it.pos;
      req_red        <= it.red;
      req_green      <= it.green;
      req_blue       <= it.blue;
      req_alpha      <= it.alpha;
      req_size_value <= it.size;
      req_rotation   <= it.rot;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge: the table moves on whatever is written below
      due = predict_ramp(it);
      if (typed) due = want;
      awaited_results = {awaited_results, due};
   endtask

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // result side: compare every accepted result with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            $error("result with nothing owed, status %0d", rsp_status);
            mismatches++;
         end else begin
            arrived = awaited_results.pop_front();
            check_field("out_red", arrived.red, rsp_out_red);
            check_field("out_green", arrived.green, rsp_out_green);
            check_field("out_blue", arrived.blue, rsp_out_blue);
            check_field("out_alpha", arrived.alpha, rsp_out_alpha);
            check_field("out_size", arrived.size, rsp_out_size);
            check_field("out_rotation", arrived.rot, rsp_out_rotation);
            check_field("status", arrived.status, rsp_status);
         end
      end
   end

   // receiver: random back-pressure, one long hold-off so the block backs up
   initial begin
      bit held;

      held = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && results_seen >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 37);
         end
      end
   end

   // watchdog on the whole run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("gradient_key_interpolator_top test failed");
      $finish;
   end

   // stimulus: reset, directed rows, then the random run
   initial begin
      gradient_req_type it;

      mismatches     = 0;
      results_seen   = 0;
      calm           = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_INSERT;
      req_position   = '0;
      req_red        = '0;
      req_green      = '0;
      req_blue       = '0;
      req_alpha      = '0;
      req_size_value = '0;
      req_rotation   = '0;

      // mirror of the table after reset
      ramp_key_count = 2;
      foreach (ramp_keys[i]) ramp_keys[i] = '0;
      ramp_keys[0] = '{'0, END0_COLOR, END_SIZE, 16'sd0};
      ramp_keys[1] = '{POS_ONE, END1_COLOR, END_SIZE, 16'sd0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_N; r++)
         offer_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a stretch where neither side idles
         calm = (n >= 300 && n < 450);
         it = draw_ramp_item(n);
         offer_item(it, 1'b0, NO_RESULT);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain, then allow for a late stray result
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("gradient_key_interpolator_top test passed");
      end else begin
         $display("gradient_key_interpolator_top test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/gki_pkg.sv
design/gradient_key_interpolator_top.sv
design/gki_checker.sv
verif/testbench.sv
